### sv/bvm_pkg.sv
// Shared types and constants for the battery voltage monitor.
// Used by bvm_div and battery_voltage_monitor; no dependencies.
package bvm_pkg;

    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DIVISOR_W    = 10;
    localparam int VOLTS_W      = 16;
    localparam int SAMPLE_IN_W  = 12;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_RISE_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FALL_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_DIVISOR  = 2'd2;

    localparam logic [VOLTS_W-1:0]   RISE_RESET = 16'd136;
    localparam logic [VOLTS_W-1:0]   FALL_RESET = 16'd133;
    localparam logic [DIVISOR_W-1:0] DIV_RESET  = 10'd184;
    localparam logic [VOLTS_W-1:0]   VOLTS_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_AVG,
        ST_SCALE,
        ST_OUT
    } bvm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### sv/bvm_div.sv
// Restoring divider, one quotient bit per cycle, for the battery voltage monitor.
// Depends on bvm_pkg (div_stat_t). Divisor zero yields an all-ones quotient.
module bvm_div #(
    parameter int DVD_W = 16,
    parameter int DVS_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output bvm_pkg::div_stat_t stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             q_bit;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        q_bit   = (rem_sh >= {1'b0, dvs_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], q_bit};
            // remainder stays below the divisor, so the top bit drops
            rem_next = q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### sv/battery_voltage_monitor.sv
// Battery voltage monitor: moving average, scaling to tenths of a volt, hysteresis warning.
// Steps after the input transfer: ring update, reciprocal average, the bit-serial scale divider
// over DVD_W quotient bits, output load. Only one item is in work: the next sample is taken
// after the output load, which waits while a held result blocks it. Reset (aresetn low,
// synchronous): ring reads zero via valid bits, sum/pointer/warning cleared, registers 136/133/184.
// Uses bvm_pkg, bvm_div.
module battery_voltage_monitor #(
    parameter int AVG_DEPTH   = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bvm_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] sample, rest zero
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bvm_pkg::M_TDATA_W-1:0]     m_tdata,   // [15:0] volts_tenths,
                                                         // [16] low_warning,
                                                         // [17] warning_changed
    // configuration write port
    input  logic                              cfg_we,
    input  logic [bvm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // Sizing: the running sum never wraps; the divider dividend holds
    // ten times the average.
    localparam int SUM_MAX = AVG_DEPTH * ((1 << SAMPLE_BITS) - 1);
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int TEN_W   = SAMPLE_BITS + 4;
    localparam int DVD_W   = TEN_W;
    localparam int PTR_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int VOLTS_W = bvm_pkg::VOLTS_W;

    // sum / AVG_DEPTH by reciprocal multiplication, exact over the whole sum range
    localparam int AVG_SH = SUM_W + $clog2(AVG_DEPTH);
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam longint unsigned AVG_MUL =
        ((64'd1 << AVG_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [VOLTS_W-1:0]            rise_reg;
    logic [VOLTS_W-1:0]            fall_reg;
    logic [bvm_pkg::DIVISOR_W-1:0] div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg <= bvm_pkg::RISE_RESET;
            fall_reg <= bvm_pkg::FALL_RESET;
            div_reg  <= bvm_pkg::DIV_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bvm_pkg::REG_RISE_THRESHOLD: rise_reg <= cfg_wdata;
                bvm_pkg::REG_FALL_THRESHOLD: fall_reg <= cfg_wdata;
                bvm_pkg::REG_SCALE_DIVISOR:  div_reg  <= cfg_wdata[bvm_pkg::DIVISOR_W-1:0];
                default: ;   // unknown index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control state and datapath registers
    // ---------------------------------------------------------------
    bvm_pkg::bvm_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [AVG_DEPTH-1:0]   valid_reg, valid_next;
    logic                   warn_reg, warn_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [VOLTS_W-1:0]     m_volts_reg;
    logic                   m_warn_reg;
    logic                   m_changed_reg;

    // control decode
    logic accept;
    logic ring_we;
    logic div_start;
    logic out_load;

    // ---------------------------------------------------------------
    // Sample ring: one synchronous memory, read at the write pointer.
    // Entries never written since reset read as zero through valid_reg.
    // Only one item is in work, so the read-modify-write on an entry
    // never overlaps another access to it.
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] ring_mem [AVG_DEPTH];
    logic [SAMPLE_BITS-1:0] ring_rd_reg;
    logic [SAMPLE_BITS-1:0] old_sample;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ptr_reg] <= sample_reg;
        end
        ring_rd_reg <= ring_mem[ptr_reg];
    end

    assign old_sample = valid_reg[ptr_reg] ? ring_rd_reg : '0;

    // ---------------------------------------------------------------
    // Average and scale divider
    // ---------------------------------------------------------------
    logic [PROD_W-1:0]             avg_prod;
    logic [SAMPLE_BITS-1:0]        avg;
    logic [DVD_W-1:0]              avg_ext;
    logic [DVD_W-1:0]              div_dividend;
    logic [bvm_pkg::DIVISOR_W-1:0] div_divisor;
    logic [DVD_W-1:0]              div_quo;
    bvm_pkg::div_stat_t            div_stat;
    logic [DVD_W-1:0]              tens_avg;

    // product >> AVG_SH is at most 2^SAMPLE_BITS - 1
    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_MUL);
    assign avg      = avg_prod[AVG_SH +: SAMPLE_BITS];
    assign avg_ext  = DVD_W'(avg);

    // 10 * average as shift-and-add
    assign tens_avg = (avg_ext << 3) + (avg_ext << 1);

    assign div_dividend = tens_avg;
    assign div_divisor  = div_reg;

    bvm_div #(
        .DVD_W (DVD_W),
        .DVS_W (bvm_pkg::DIVISOR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // ---------------------------------------------------------------
    // Scaling result and hysteresis
    // ---------------------------------------------------------------
    logic [31:0]        quo_wide;
    logic [VOLTS_W-1:0] volts;
    logic               warn_new;
    logic               warn_toggle;

    always_comb begin
        quo_wide = 32'(div_quo);
        if (div_reg == '0) begin
            volts = bvm_pkg::VOLTS_MAX;
        end else if (quo_wide > 32'(bvm_pkg::VOLTS_MAX)) begin
            volts = bvm_pkg::VOLTS_MAX;
        end else begin
            volts = quo_wide[VOLTS_W-1:0];
        end

        // clear is tested only while set, set only while clear
        if (warn_reg) begin
            warn_toggle = (volts > rise_reg);
        end else begin
            warn_toggle = (volts < fall_reg);
        end
        warn_new = warn_reg ^ warn_toggle;
    end

    // ---------------------------------------------------------------
    // FSM: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bvm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = bvm_pkg::ST_UPDATE;
                end
            end
            bvm_pkg::ST_UPDATE: begin
                state_next = bvm_pkg::ST_AVG;
            end
            bvm_pkg::ST_AVG: begin
                state_next = bvm_pkg::ST_SCALE;
            end
            bvm_pkg::ST_SCALE: begin
                if (div_stat.done) begin
                    state_next = bvm_pkg::ST_OUT;
                end
            end
            bvm_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = bvm_pkg::ST_IDLE;
                end
            end
            default: state_next = bvm_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // FSM: outputs
    // ---------------------------------------------------------------
    always_comb begin
        s_tready  = 1'b0;
        ring_we   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            bvm_pkg::ST_IDLE:   s_tready  = 1'b1;
            bvm_pkg::ST_UPDATE: ring_we   = 1'b1;
            bvm_pkg::ST_AVG:    div_start = 1'b1;
            bvm_pkg::ST_SCALE:  ;
            bvm_pkg::ST_OUT:    out_load  = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    localparam int S_EXT_W = 16;
    logic [S_EXT_W-1:0] s_ext;

    assign s_ext = S_EXT_W'(s_tdata[bvm_pkg::SAMPLE_IN_W-1:0]);

    always_comb begin
        sum_next   = sum_reg;
        ptr_next   = ptr_reg;
        valid_next = valid_reg;
        warn_next  = warn_reg;

        if (state_reg == bvm_pkg::ST_UPDATE) begin
            sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
            valid_next[ptr_reg] = 1'b1;
            if (ptr_reg == PTR_W'(AVG_DEPTH - 1)) begin
                ptr_next = '0;
            end else begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end
        if (out_load) begin
            warn_next = warn_new;
        end

        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bvm_pkg::ST_IDLE;
            sum_reg      <= '0;
            ptr_reg      <= '0;
            valid_reg    <= '0;
            warn_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            ptr_reg      <= ptr_next;
            valid_reg    <= valid_next;
            warn_reg     <= warn_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (accept) begin
            sample_reg <= s_ext[SAMPLE_BITS-1:0];
        end
        if (out_load) begin
            m_volts_reg   <= volts;
            m_warn_reg    <= warn_new;
            m_changed_reg <= warn_toggle;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_changed_reg, m_warn_reg, m_volts_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("input taken while the divider is busy");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sum_reg) <= 32'(SUM_MAX))
        else $error("running sum exceeds its bound");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < 32'(AVG_DEPTH))
        else $error("ring pointer out of range");

    a_changed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_changed_reg == (warn_reg != $past(warn_reg))))
        else $error("warning_changed disagrees with warning flag update");

endmodule

### test/battery_voltage_monitor_test.sv
// Testbench for battery_voltage_monitor: directed and random samples on the input stream,
// each result checked field by field against a predictor of the average and the warning.
// Depends on bvm_pkg and the battery_voltage_monitor RTL.
module battery_voltage_monitor_test;

    localparam int AVG_LEN     = 10;       // matches the DUT default AVG_DEPTH
    localparam int SAMPLE_W    = 12;       // matches the DUT default SAMPLE_BITS
    localparam int TENTHS      = 10;
    localparam int LATENCY     = 20;       // input transfer to result valid at defaults
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off, well past one item
    localparam int CYCLE_LIMIT = 1000000;
    localparam int BLOCK_ITEMS = 110;      // random items between setting changes
    localparam logic [bvm_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;  // no register here

    // result fields, highest bit first in m_tdata
    typedef struct packed {
        logic                        changed;
        logic                        low;
        logic [bvm_pkg::VOLTS_W-1:0] volts;
    } reading_t;

    // Predicts each reading from the accepted samples and checks the DUT against it.
    class volts_scoreboard;
        logic [SAMPLE_W-1:0]           ring [AVG_LEN];
        int unsigned                   slot;
        int unsigned                   sum;
        bit                            warn;
        logic [bvm_pkg::VOLTS_W-1:0]   rise;
        logic [bvm_pkg::VOLTS_W-1:0]   fall;
        logic [bvm_pkg::DIVISOR_W-1:0] divisor;
        reading_t                      expected_readings[$];
        int                            error_count;

        function new();
            foreach (ring[i]) ring[i] = '0;
            slot        = 0;
            sum         = 0;
            warn        = 1'b0;
            rise        = bvm_pkg::RISE_RESET;
            fall        = bvm_pkg::FALL_RESET;
            divisor     = bvm_pkg::DIV_RESET;
            error_count = 0;
        endfunction

        function void write_register(logic [bvm_pkg::CFG_ADDR_W-1:0] addr,
                                     logic [bvm_pkg::CFG_DATA_W-1:0] data);
            unique case (addr)
                bvm_pkg::REG_RISE_THRESHOLD: rise = data;
                bvm_pkg::REG_FALL_THRESHOLD: fall = data;
                bvm_pkg::REG_SCALE_DIVISOR:  divisor = data[bvm_pkg::DIVISOR_W-1:0];
                default: ;  // out-of-range index, ignored
            endcase
        endfunction

        // Note one accepted sample and queue the reading it must produce.
        function void take_sample(logic [SAMPLE_W-1:0] smp);
            reading_t    r;
            int unsigned avg;
            int unsigned v;
            sum = sum - 32'(ring[slot]) + 32'(smp);
            ring[slot] = smp;
            slot = (slot + 1) % AVG_LEN;
            avg = sum / AVG_LEN;
            if (divisor == 0) begin
                v = 32'(bvm_pkg::VOLTS_MAX);
            end else begin
                v = (TENTHS * avg) / divisor;
                if (v > 32'(bvm_pkg::VOLTS_MAX)) v = 32'(bvm_pkg::VOLTS_MAX);
            end
            r.changed = 1'b0;
            // clear tested first while set; at most one toggle per sample
            if (warn && v > 32'(rise)) begin
                warn = 1'b0;
                r.changed = 1'b1;
            end else if (!warn && v < 32'(fall)) begin
                warn = 1'b1;
                r.changed = 1'b1;
            end
            r.volts = v[bvm_pkg::VOLTS_W-1:0];
            r.low   = warn;
            expected_readings.push_back(r);
        endfunction

        task flag_error(string msg);
            error_count++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_reading(logic [bvm_pkg::M_TDATA_W-1:0] data);
            reading_t got;
            reading_t want;
            got = data[$bits(reading_t)-1:0];
            if (expected_readings.size() == 0) begin
                flag_error($sformatf("result %h with no sample pending", data));
                return;
            end
            want = expected_readings.pop_front();
            if (got.volts !== want.volts)
                flag_error($sformatf("volts_tenths %0d, want %0d", got.volts, want.volts));
            if (got.low !== want.low)
                flag_error($sformatf("low_warning %b, want %b", got.low, want.low));
            if (got.changed !== want.changed)
                flag_error($sformatf("warning_changed %b, want %b",
                                     got.changed, want.changed));
        endtask

        task flush_leftovers();
            while (expected_readings.size() != 0) begin
                void'(expected_readings.pop_front());
                flag_error("reading never produced");
            end
        endtask
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [bvm_pkg::S_TDATA_W-1:0]    s_tdata;     // [11:0] sample, rest zero
    logic                             m_tvalid;
    logic                             m_tready;
    logic [bvm_pkg::M_TDATA_W-1:0]    m_tdata;     // [15:0] volts_tenths, [16] low_warning,
                                                   // [17] warning_changed
    logic                             cfg_we;
    logic [bvm_pkg::CFG_ADDR_W-1:0]   cfg_addr;
    logic [bvm_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    volts_scoreboard sb;
    int              send_idle_pct = 0;   // sender idle chance per cycle, percent
    int              recv_idle_pct = 0;   // receiver idle chance per cycle, percent
    bit              hold_request  = 1'b0;
    int unsigned     cycle_count   = 0;

    battery_voltage_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Transfer monitor. Runs in the active region of the edge, so it sees the
    // pre-edge values of both handshakes, the same values the DUT samples.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_sample(s_tdata[SAMPLE_W-1:0]);
            if (m_tvalid && m_tready) sb.check_reading(m_tdata);
        end
    end

    // Result side: ready drops in recv_idle_pct of the cycles; the first hold
    // request parks m_tready low for HOLD_CYCLES so the result backs up and
    // the DUT stops taking samples.
    initial begin
        int stall_left;
        bit hold_seen;
        stall_left = 0;
        hold_seen  = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_seen) begin
                hold_seen  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One sample transfer. Idle cycles come only before valid rises, so valid
    // is never dropped while a sample is offered.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bvm_pkg::S_TDATA_W-SAMPLE_W){1'b0}}, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait for every queued reading; the DUT is idle afterwards.
    // The extra edge lets the monitor note the last sample first.
    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bvm_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [bvm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_register(addr, data);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // New thresholds around a level the current divisor can reach, so the
    // warning keeps toggling; sometimes crossed, sometimes raw random words.
    task automatic random_settings();
        int unsigned dv;
        int unsigned upper;
        int unsigned top;
        int unsigned center;
        int unsigned band;
        int unsigned hi;
        int unsigned lo;
        int unsigned rnd_a;
        int unsigned rnd_b;
        logic [bvm_pkg::CFG_DATA_W-1:0] rise_v;
        logic [bvm_pkg::CFG_DATA_W-1:0] fall_v;
        upper = $urandom_range(63);   // dead bits above the divisor field
        case ($urandom_range(9))
            0:       dv = 0;
            1:       dv = 1;
            2:       dv = 1023;
            default: dv = $urandom_range(1023, 1);
        endcase
        top    = (dv == 0) ? 65535 : (TENTHS * 4095) / dv;
        center = $urandom_range(top);
        band   = $urandom_range(top / 8);
        hi     = (center + band > 65535) ? 65535 : center + band;
        lo     = (center < band) ? 0 : center - band;
        rnd_a  = $urandom;
        rnd_b  = $urandom;
        if ($urandom_range(7) == 0) begin
            rise_v = rnd_a[15:0];
            fall_v = rnd_b[15:0];
        end else if ($urandom_range(4) == 0) begin
            rise_v = lo[15:0];   // fall above rise
            fall_v = hi[15:0];
        end else begin
            rise_v = hi[15:0];
            fall_v = lo[15:0];
        end
        if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 16'($urandom));
        write_reg(bvm_pkg::REG_RISE_THRESHOLD, rise_v);
        write_reg(bvm_pkg::REG_FALL_THRESHOLD, fall_v);
        write_reg(bvm_pkg::REG_SCALE_DIVISOR, {upper[5:0], dv[9:0]});
    endtask

    // Mostly runs of samples around a held level with noise, so the average
    // settles and crosses the thresholds; the rest is extremes and raw noise.
    task automatic random_items(input int count);
        int sent;
        int run;
        int level;
        int spread;
        int val;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) < 7) begin
                level  = int'($urandom_range(4095));
                spread = int'($urandom_range(200));
                run    = int'($urandom_range(30, 5));
                if (run > count - sent) run = count - sent;
                repeat (run) begin
                    val = level + int'($urandom_range(2 * spread)) - spread;
                    if (val < 0) val = 0;
                    if (val > 4095) val = 4095;
                    send_sample(val[SAMPLE_W-1:0]);
                    sent++;
                end
            end else begin
                case ($urandom_range(3))
                    0:       send_sample('0);
                    1:       send_sample('1);
                    default: send_sample(SAMPLE_W'($urandom_range(4095)));
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // start-up at reset settings: zero ring, so the first sample sets the
        // warning; a full ring of max samples ramps the average up and clears it
        send_sample('0);
        repeat (AVG_LEN) send_sample('1);
        send_sample(12'hAAA);
        send_sample(12'h555);
        end_burst();

        // out-of-range index must not land anywhere; divisor zero saturates
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(bvm_pkg::REG_SCALE_DIVISOR, 16'hFC00);
        write_reg(bvm_pkg::REG_RISE_THRESHOLD, 16'hFFFF);
        write_reg(bvm_pkg::REG_FALL_THRESHOLD, 16'h0000);
        send_sample('1);
        send_sample('0);
        end_burst();

        // crossed thresholds, widest divisor (upper bits of the word dropped)
        write_reg(bvm_pkg::REG_RISE_THRESHOLD, 16'd100);
        write_reg(bvm_pkg::REG_FALL_THRESHOLD, 16'd200);
        write_reg(bvm_pkg::REG_SCALE_DIVISOR, 16'hFFFF);
        repeat (3) send_sample('0);
        end_burst();
        write_reg(bvm_pkg::REG_SCALE_DIVISOR, 16'd1);
        repeat (2) send_sample('1);
        end_burst();

        // extreme thresholds: the flag toggles on every sample
        write_reg(bvm_pkg::REG_RISE_THRESHOLD, 16'd0);
        write_reg(bvm_pkg::REG_FALL_THRESHOLD, 16'hFFFF);
        repeat (4) send_sample(SAMPLE_W'($urandom_range(4095)));
        end_burst();

        // --- random part: three idling profiles, settings changed per block ---
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 37 : 0;
            for (int blk = 0; blk < 5; blk++) begin
                random_settings();
                if (ph == 0 && blk == 1) hold_request = 1'b1;
                random_items(BLOCK_ITEMS);
                end_burst();
            end
        end

        repeat (LATENCY) @(posedge aclk);
        sb.flush_leftovers();
        if (sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### battery_voltage_monitor.f
sv/bvm_pkg.sv
sv/bvm_div.sv
sv/battery_voltage_monitor.sv
test/battery_voltage_monitor_test.sv
